### hw/rtl/sdpr_pkg.sv
// sdpr_pkg: shared types, codes and constants of the segment display pixel renderer
// depends on nothing; imported by every module of the block
`default_nettype none

package sdpr_pkg;

  localparam int unsigned NumPos      = 8;
  localparam int unsigned PosW        = 3;
  localparam int unsigned CountW      = 4;
  localparam int unsigned FifoDepth   = 4;
  localparam int unsigned FifoPtrW    = 2;
  localparam int unsigned InDataW     = 40;
  localparam int unsigned OutDataW    = 48;
  localparam int unsigned PixW        = 14;
  localparam int unsigned AddrW       = 4;

  localparam logic [2:0] ActTick   = 3'd0;
  localparam logic [2:0] ActValue  = 3'd1;
  localparam logic [2:0] ActColour = 3'd2;
  localparam logic [2:0] ActBlink  = 3'd3;
  localparam logic [2:0] ActRender = 3'd4;

  localparam logic [1:0] KindEmpty = 2'd0;
  localparam logic [1:0] KindDigit = 2'd1;
  localparam logic [1:0] KindDot   = 2'd2;
  localparam logic [1:0] KindColon = 2'd3;

  localparam logic [1:0] RegCount    = 2'd0;
  localparam logic [1:0] RegLayout   = 2'd1;
  localparam logic [1:0] RegLeds     = 2'd2;
  localparam logic [1:0] RegInterval = 2'd3;

  localparam logic [3:0]  CountReset    = 4'd8;
  localparam logic [15:0] LayoutReset   = 16'd0;
  localparam logic [7:0]  LedsReset     = 8'd1;
  localparam logic [12:0] IntervalReset = 13'd500;
  localparam logic [12:0] IntervalMin   = 13'd100;
  localparam logic [12:0] IntervalMax   = 13'd5000;
  localparam logic [23:0] ColourReset   = {8'd50, 8'd0, 8'd0};
  localparam logic [3:0]  TimeModLast   = 4'd9;

  typedef enum logic [1:0] {
    OP_VALUE,
    OP_COLOUR,
    OP_BLINK,
    OP_RENDER
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  mask;
    logic [7:0]  value;
    logic [23:0] rgb;
    logic        blink_on;
    logic [31:0] time_ms;
    logic [3:0]  time_mod10;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  position_count;
    logic [15:0] layout_codes;
    logic [7:0]  leds_per_segment;
    logic [12:0] blink_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [13:0] pixel_start;
    logic [7:0]  run_length;
    logic [23:0] rgb;
    logic        last_run;
  } run_t;

  function automatic logic [3:0] active_count(input logic [3:0] count);
    logic [3:0] lim;
    lim = CountW'(NumPos);
    return (count > lim) ? lim : count;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sdpr_fifo.sv
// sdpr_fifo: short command queue between the front and the render engine
// depends on sdpr_pkg for the command type and depth
`default_nettype none

module sdpr_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire sdpr_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output sdpr_pkg::cmd_t     head_o
);
  import sdpr_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == (FifoPtrW+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (FifoPtrW+1)'(FifoDepth))
    else $error("queue fill count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into a full queue");

endmodule

`default_nettype wire

### hw/rtl/sdpr_front.sv
// sdpr_front: accepts input beats, keeps the millisecond clock, classifies writes
// depends on sdpr_pkg; feeds commands to sdpr_fifo
`default_nettype none

module sdpr_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [2:0]                   in_user_i,
  input  wire logic [sdpr_pkg::InDataW-1:0] in_data_i,
  input  wire logic [3:0]                   position_count_i,
  input  wire logic                         fifo_full_i,
  output logic                              push_o,
  output sdpr_pkg::cmd_t                    cmd_o
);
  import sdpr_pkg::*;

  logic [31:0]     time_q;
  logic [3:0]      mod10_q;
  logic            accept, want;
  logic [PosW-1:0] pos;
  logic            all_pos;
  logic [3:0]      cnt;
  logic [7:0]      below_mask, single_mask, mask;
  op_e             op;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos        = in_data_i[2:0];
  assign all_pos    = in_data_i[3];
  assign cnt        = active_count(position_count_i);

  always_comb begin
    for (int i = 0; i < NumPos; i++) begin
      below_mask[i] = (CountW'(i) < cnt);
    end
    single_mask = ({1'b0, pos} < cnt) ? (8'd1 << pos) : 8'd0;
    op   = OP_RENDER;
    mask = 8'd0;
    want = 1'b0;
    case (in_user_i)
      ActValue: begin
        op   = OP_VALUE;
        mask = all_pos ? 8'hff : single_mask;
        want = (mask != 8'd0);
      end
      ActColour: begin
        op   = OP_COLOUR;
        mask = all_pos ? below_mask : single_mask;
        want = (mask != 8'd0);
      end
      ActBlink: begin
        op   = OP_BLINK;
        mask = all_pos ? 8'hff : single_mask;
        want = (mask != 8'd0);
      end
      ActRender: begin
        op   = OP_RENDER;
        want = 1'b1;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  assign push_o = accept && want;

  always_comb begin
    cmd_o.op         = op;
    cmd_o.mask       = mask;
    cmd_o.value      = in_data_i[11:4];
    cmd_o.rgb        = {in_data_i[19:12], in_data_i[27:20], in_data_i[35:28]};
    cmd_o.blink_on   = in_data_i[36];
    cmd_o.time_ms    = time_q;
    cmd_o.time_mod10 = mod10_q;
  end

  // time modulo ten restarts at the 32-bit wrap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      mod10_q <= '0;
    end else if (accept && (in_user_i == ActTick)) begin
      time_q <= time_q + 32'd1;
      if (time_q == '1 || mod10_q == TimeModLast) begin
        mod10_q <= '0;
      end else begin
        mod10_q <= mod10_q + 4'd1;
      end
    end
  end

  a_mod10_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod10_q <= TimeModLast)
    else $error("time modulo ten out of range");

endmodule

`default_nettype wire

### hw/rtl/sdpr_render.sv
// sdpr_render: position store, blink phase and run walker with output register
// depends on sdpr_pkg; pops commands from sdpr_fifo
`default_nettype none

module sdpr_render (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire sdpr_pkg::cfg_t cfg_i,
  input  wire logic          cmd_valid_i,
  input  wire sdpr_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output sdpr_pkg::run_t     out_run_o
);
  import sdpr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e          state_q;
  logic [7:0]      pattern_q [NumPos];
  logic [23:0]     colour_q  [NumPos];
  logic [NumPos-1:0] blink_q;
  logic [31:0]     last_toggle_q;
  logic            phase_q;
  logic [3:0]      pos_q;
  logic [2:0]      seg_q;
  logic [PixW-1:0] pixel_q;
  run_t            pend_q, out_q;
  logic            pend_valid_q, out_valid_q;

  logic [3:0]      cnt;
  logic [PosW-1:0] idx;
  logic [1:0]      kind;
  logic            shine, elem_lit, done, skip, can_move, gen_ok, last_seg;
  logic [7:0]      len;
  run_t            new_run;
  logic            toggle;

  assign cnt      = active_count(cfg_i.position_count);
  assign idx      = pos_q[PosW-1:0];
  assign kind     = cfg_i.layout_codes[{idx, 1'b0} +: 2];
  assign shine    = blink_q[idx] ? phase_q : 1'b1;
  assign done     = (pos_q >= cnt);
  assign skip     = (kind == KindEmpty) || (kind == KindDigit && cfg_i.leds_per_segment == 8'd0);
  assign can_move = !out_valid_q || out_ready_i;
  assign gen_ok   = !pend_valid_q || can_move;
  assign last_seg = (kind != KindDigit) || (seg_q == 3'd6);
  assign toggle   = (cmd_i.time_ms >= (last_toggle_q + {19'd0, cfg_i.blink_interval_ms}));
  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  always_comb begin
    case (kind)
      KindDigit: begin
        len      = cfg_i.leds_per_segment;
        elem_lit = pattern_q[idx][3'd7 - seg_q];
      end
      KindDot: begin
        len      = 8'd1;
        elem_lit = (pattern_q[idx] != 8'd0);
      end
      KindColon: begin
        len      = 8'd2;
        elem_lit = (pattern_q[idx] != 8'd0);
      end
      default: begin
        len      = 8'd0;
        elem_lit = 1'b0;
      end
    endcase
    new_run.pixel_start = pixel_q;
    new_run.run_length  = len;
    new_run.rgb         = (elem_lit && shine) ? colour_q[idx] : 24'd0;
    new_run.last_run    = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      for (int i = 0; i < NumPos; i++) begin
        pattern_q[i] <= 8'd0;
        colour_q[i]  <= ColourReset;
      end
      blink_q       <= '0;
      last_toggle_q <= '0;
      phase_q       <= 1'b0;
      pos_q         <= '0;
      seg_q         <= '0;
      pixel_q       <= '0;
      pend_q        <= '0;
      out_q         <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.op)
              OP_VALUE: begin
                for (int i = 0; i < NumPos; i++) begin
                  if (cmd_i.mask[i]) pattern_q[i] <= cmd_i.value;
                end
              end
              OP_COLOUR: begin
                for (int i = 0; i < NumPos; i++) begin
                  if (cmd_i.mask[i]) colour_q[i] <= cmd_i.rgb;
                end
              end
              OP_BLINK: begin
                for (int i = 0; i < NumPos; i++) begin
                  if (cmd_i.mask[i]) blink_q[i] <= cmd_i.blink_on;
                end
              end
              default: begin
                if (toggle) begin
                  phase_q       <= !phase_q;
                  last_toggle_q <= cmd_i.time_ms - {28'd0, cmd_i.time_mod10};
                end
                pos_q   <= '0;
                seg_q   <= '0;
                pixel_q <= '0;
                state_q <= ST_WALK;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (done) begin
            if (!pend_valid_q) begin
              state_q <= ST_IDLE;
            end else if (can_move) begin
              out_q          <= pend_q;
              out_q.last_run <= 1'b1;
              out_valid_q    <= 1'b1;
              pend_valid_q   <= 1'b0;
              state_q        <= ST_IDLE;
            end
          end else if (skip) begin
            pos_q <= pos_q + 4'd1;
            seg_q <= '0;
          end else if (gen_ok) begin
            if (pend_valid_q) begin
              out_q       <= pend_q;
              out_valid_q <= 1'b1;
            end
            pend_q       <= new_run;
            pend_valid_q <= 1'b1;
            pixel_q      <= pixel_q + {6'd0, len};
            if (last_seg) begin
              seg_q <= '0;
              pos_q <= pos_q + 4'd1;
            end else begin
              seg_q <= seg_q + 3'd1;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_run_o   = out_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("held run left behind after a frame");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= CountW'(NumPos))
    else $error("walk position beyond the store");

  a_seg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q <= 3'd6)
    else $error("segment counter beyond the seventh segment");

endmodule

`default_nettype wire

### hw/rtl/segment_display_pixel_renderer.sv
// segment_display_pixel_renderer: top level with register port, front, queue and render engine
// depends on sdpr_pkg, sdpr_front, sdpr_fifo and sdpr_render
//
//  channel    direction  beat fields
//  s_axis     in         tuser action; tdata position..blink_on
//  m_axis     out        tdata pixel_start..blue_out; tlast last_run
//  apb        in/out     4 registers at byte addresses 0, 4, 8, 12
//
// ticks and writes are taken one beat per cycle while the 4-entry command queue has room
// a write is applied as the engine pops it; a render first updates the blink phase, then
// walks each run and each empty or zero-width position in turn, then closes the frame
// the engine stalls only on m_axis tready; the front keeps taking beats until the queue is full
// no clearing pass after reset: every store has its reset value at once
`default_nettype none

module segment_display_pixel_renderer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // action
  input  wire logic [2:0]                    s_axis_tuser_i,
  // position, all_positions, seg_value, red_in, green_in, blue_in, blink_on, zero fill
  input  wire logic [sdpr_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // pixel_start, run_length, red_out, green_out, blue_out, zero fill
  output logic [sdpr_pkg::OutDataW-1:0]      m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sdpr_pkg::AddrW-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import sdpr_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_we;
  logic [1:0] reg_idx;
  logic       push, fifo_full, pop, cmd_valid, run_valid;
  cmd_t       push_cmd, head_cmd;
  run_t       run;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.position_count    <= CountReset;
      cfg_q.layout_codes      <= LayoutReset;
      cfg_q.leds_per_segment  <= LedsReset;
      cfg_q.blink_interval_ms <= IntervalReset;
    end else if (cfg_we) begin
      case (reg_idx)
        RegCount:  cfg_q.position_count   <= pwdata[3:0];
        RegLayout: cfg_q.layout_codes     <= pwdata[15:0];
        RegLeds:   cfg_q.leds_per_segment <= pwdata[7:0];
        RegInterval: begin
          if (pwdata[12:0] >= IntervalMin && pwdata[12:0] <= IntervalMax) begin
            cfg_q.blink_interval_ms <= pwdata[12:0];
          end
        end
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegCount:    prdata = {28'd0, cfg_q.position_count};
      RegLayout:   prdata = {16'd0, cfg_q.layout_codes};
      RegLeds:     prdata = {24'd0, cfg_q.leds_per_segment};
      RegInterval: prdata = {19'd0, cfg_q.blink_interval_ms};
      default:     prdata = 32'd0;
    endcase
  end

  sdpr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid_i),
    .in_ready_o       (s_axis_tready_o),
    .in_user_i        (s_axis_tuser_i),
    .in_data_i        (s_axis_tdata_i),
    .position_count_i (cfg_q.position_count),
    .fifo_full_i      (fifo_full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  sdpr_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (cmd_valid),
    .head_o     (head_cmd)
  );

  sdpr_render u_render (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (pop),
    .out_valid_o (run_valid),
    .out_ready_i (m_axis_tready_i),
    .out_run_o   (run)
  );

  assign m_axis_tvalid_o = run_valid;
  assign m_axis_tdata_o  = {2'd0, run.rgb[7:0], run.rgb[15:8], run.rgb[23:16],
                            run.run_length, run.pixel_start};
  assign m_axis_tlast_o  = run.last_run;

endmodule

`default_nettype wire
